/* hw/rtl/ac_pkg.sv */
// ----------------------------------------------------------------------------
// ac_pkg: shared types and constants of the Aho-Corasick matcher
// Table sizes, request and status codes, and the request and result records.
// ----------------------------------------------------------------------------
package ac_pkg;

  localparam int NODES             = 256;
  localparam int ALPHABET          = 256;
  localparam int MAX_SIGS          = 256;
  localparam int MAX_HITS_PER_BYTE = 63;

  localparam int NODE_W  = $clog2(NODES);
  localparam int BYTE_W  = $clog2(ALPHABET);
  localparam int TT_AW   = NODE_W + BYTE_W;
  localparam int TT_DEPTH = NODES * ALPHABET;
  localparam int SIG_AW  = $clog2(MAX_SIGS);
  // A signature pointer carries one more bit so that it can hold the null value.
  localparam int SIG_PW  = SIG_AW + 1;
  localparam int OL_W    = 2 * SIG_PW;
  localparam int HIT_W   = $clog2(MAX_HITS_PER_BYTE + 1);

  localparam logic [SIG_PW-1:0] SIG_NIL = SIG_PW'(MAX_SIGS);

  localparam logic [1:0] REQ_INSERT = 2'd0;
  localparam logic [1:0] REQ_BUILD  = 2'd1;
  localparam logic [1:0] REQ_SCAN   = 2'd2;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [1:0] ST_INVALID   = 2'd2;
  localparam logic [1:0] ST_FULL      = 2'd3;

  localparam logic KIND_HIT    = 1'b0;
  localparam logic KIND_STATUS = 1'b1;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [7:0]  data_byte;
    logic        first;
    logic        last;
    logic [31:0] pattern_sig;
  } in_req_t;

  typedef struct packed {
    logic        result_kind;
    logic [31:0] hit_signature;
    logic [15:0] match_total;
    logic [1:0]  status;
    logic        truncated;
    logic        last_result;
  } out_res_t;

endpackage

/* hw/rtl/aho_corasick_matcher.sv */
// ----------------------------------------------------------------------------
// aho_corasick_matcher: byte-wide multi-pattern matcher
// Trie insertion, breadth-first automaton build and byte scanning, all run
// by one sequencer over a set of table memories.
// ----------------------------------------------------------------------------
// After reset the block clears its transition table, one entry per cycle,
// and its failure links and signature lists, while busy is high. A request
// is taken when start is high and busy is low; busy then stays high until
// the request is done, and the hit limit register may be written at any
// time while idle. Results appear with out_valid for one cycle each and
// cannot be stalled. Every step is a sequence of single reads and writes to
// the tables, each read registered in its RAM: an insert byte reads one
// transition and may add a node, a scan byte walks the failure chain twice,
// once to count its hits and once to emit them, and a build queues the root's
// children, then visits each queued trie node once across the whole alphabet.
module aho_corasick_matcher (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  output logic            busy,
  input  ac_pkg::in_req_t in_req,
  output logic            out_valid,
  output ac_pkg::out_res_t out_res,
  input  logic            cfg_we,
  input  logic [15:0]     cfg_wdata
);
  import ac_pkg::*;

  localparam logic [4:0] S_CLR      = 5'd0;
  localparam logic [4:0] S_IDLE     = 5'd1;
  localparam logic [4:0] S_INS      = 5'd2;
  localparam logic [4:0] S_INS_RD   = 5'd3;
  localparam logic [4:0] S_INS_END  = 5'd4;
  localparam logic [4:0] S_INS_LINK = 5'd5;
  localparam logic [4:0] S_BLD      = 5'd6;
  localparam logic [4:0] S_BR_RD    = 5'd7;
  localparam logic [4:0] S_BR_CH    = 5'd8;
  localparam logic [4:0] S_BQ       = 5'd9;
  localparam logic [4:0] S_BU       = 5'd10;
  localparam logic [4:0] S_BF       = 5'd11;
  localparam logic [4:0] S_B1       = 5'd12;
  localparam logic [4:0] S_B2       = 5'd13;
  localparam logic [4:0] S_B3       = 5'd14;
  localparam logic [4:0] S_SC       = 5'd15;
  localparam logic [4:0] S_SN       = 5'd16;
  localparam logic [4:0] S_WH       = 5'd17;
  localparam logic [4:0] S_WS       = 5'd18;
  localparam logic [4:0] S_WN       = 5'd19;
  localparam logic [4:0] S_WF       = 5'd20;
  localparam logic [4:0] S_BAD      = 5'd21;

  logic [4:0]        state_r, state_nxt;
  logic [TT_AW-1:0]  clr_r, clr_nxt;
  in_req_t           req_r, req_nxt;
  logic [NODE_W-1:0] cur_r, cur_nxt;
  logic [NODE_W:0]   nodes_r, nodes_nxt;
  logic [SIG_AW:0]   sigs_r, sigs_nxt;
  logic              built_r, built_nxt;
  logic [15:0]       hits_r, hits_nxt;
  logic [1:0]        err_r, err_nxt;
  logic [15:0]       maxm_r, maxm_nxt;
  logic [SIG_AW-1:0] sidx_r, sidx_nxt;
  logic [BYTE_W-1:0] c_r, c_nxt;
  logic [NODE_W:0]   qh_r, qh_nxt;
  logic [NODE_W:0]   qt_r, qt_nxt;
  logic [NODE_W-1:0] u_r, u_nxt;
  logic [NODE_W-1:0] f_r, f_nxt;
  logic [NODE_W-1:0] ch_r, ch_nxt;
  logic [NODE_W-1:0] nd_r, nd_nxt;
  logic [SIG_PW-1:0] s_r, s_nxt;
  logic [HIT_W-1:0]  n_r, n_nxt;
  logic [HIT_W-1:0]  ntot_r, ntot_nxt;
  logic [15:0]       hc_r, hc_nxt;
  logic              trunc_r, trunc_nxt;
  logic              pass_r, pass_nxt;
  logic              out_valid_r, out_valid_nxt;
  out_res_t          out_r, out_nxt;

  // Memory ports
  logic              tt_we;
  logic [TT_AW-1:0]  tt_waddr, tt_raddr;
  logic [NODE_W-1:0] tt_wdata, tt_rdata;
  logic              fl_we;
  logic [NODE_W-1:0] fl_waddr, fl_raddr, fl_wdata, fl_rdata;
  logic              ol_we;
  logic [NODE_W-1:0] ol_waddr, ol_raddr;
  logic [OL_W-1:0]   ol_wdata, ol_rdata;
  logic              ss_we;
  logic [SIG_AW-1:0] ss_waddr, ss_raddr;
  logic [31:0]       ss_wdata, ss_rdata;
  logic              sn_we;
  logic [SIG_AW-1:0] sn_waddr, sn_raddr;
  logic [SIG_PW-1:0] sn_wdata, sn_rdata;
  logic              q_we;
  logic [NODE_W-1:0] q_waddr, q_raddr, q_wdata, q_rdata;

  ac_ram #(.WIDTH(NODE_W), .DEPTH(TT_DEPTH)) u_tt (
    .clk(clk), .we(tt_we), .waddr(tt_waddr), .wdata(tt_wdata),
    .raddr(tt_raddr), .rdata(tt_rdata)
  );
  ac_ram #(.WIDTH(NODE_W), .DEPTH(NODES)) u_fl (
    .clk(clk), .we(fl_we), .waddr(fl_waddr), .wdata(fl_wdata),
    .raddr(fl_raddr), .rdata(fl_rdata)
  );
  ac_ram #(.WIDTH(OL_W), .DEPTH(NODES)) u_ol (
    .clk(clk), .we(ol_we), .waddr(ol_waddr), .wdata(ol_wdata),
    .raddr(ol_raddr), .rdata(ol_rdata)
  );
  ac_ram #(.WIDTH(32), .DEPTH(MAX_SIGS)) u_ss (
    .clk(clk), .we(ss_we), .waddr(ss_waddr), .wdata(ss_wdata),
    .raddr(ss_raddr), .rdata(ss_rdata)
  );
  ac_ram #(.WIDTH(SIG_PW), .DEPTH(MAX_SIGS)) u_sn (
    .clk(clk), .we(sn_we), .waddr(sn_waddr), .wdata(sn_wdata),
    .raddr(sn_raddr), .rdata(sn_rdata)
  );
  ac_ram #(.WIDTH(NODE_W), .DEPTH(NODES)) u_q (
    .clk(clk), .we(q_we), .waddr(q_waddr), .wdata(q_wdata),
    .raddr(q_raddr), .rdata(q_rdata)
  );

  logic [NODE_W-1:0] cur0;
  logic [1:0]        err0;
  logic [15:0]       hits0;
  logic [SIG_PW-1:0] ol_head, ol_tail;

  assign cur0    = req_r.first ? '0 : cur_r;
  assign err0    = req_r.first ? ST_OK : err_r;
  assign hits0   = req_r.first ? '0 : hits_r;
  assign ol_head = ol_rdata[OL_W-1:SIG_PW];
  assign ol_tail = ol_rdata[SIG_PW-1:0];

  always_comb begin
    state_nxt     = state_r;
    clr_nxt       = clr_r;
    req_nxt       = req_r;
    cur_nxt       = cur_r;
    nodes_nxt     = nodes_r;
    sigs_nxt      = sigs_r;
    built_nxt     = built_r;
    hits_nxt      = hits_r;
    err_nxt       = err_r;
    maxm_nxt      = cfg_we ? cfg_wdata : maxm_r;
    sidx_nxt      = sidx_r;
    c_nxt         = c_r;
    qh_nxt        = qh_r;
    qt_nxt        = qt_r;
    u_nxt         = u_r;
    f_nxt         = f_r;
    ch_nxt        = ch_r;
    nd_nxt        = nd_r;
    s_nxt         = s_r;
    n_nxt         = n_r;
    ntot_nxt      = ntot_r;
    hc_nxt        = hc_r;
    trunc_nxt     = trunc_r;
    pass_nxt      = pass_r;
    out_valid_nxt = 1'b0;
    out_nxt       = '0;

    tt_we = 1'b0; tt_waddr = '0; tt_wdata = '0; tt_raddr = '0;
    fl_we = 1'b0; fl_waddr = '0; fl_wdata = '0; fl_raddr = '0;
    ol_we = 1'b0; ol_waddr = '0; ol_wdata = '0; ol_raddr = '0;
    ss_we = 1'b0; ss_waddr = '0; ss_wdata = '0; ss_raddr = '0;
    sn_we = 1'b0; sn_waddr = '0; sn_wdata = '0; sn_raddr = '0;
    q_we  = 1'b0; q_waddr  = '0; q_wdata  = '0; q_raddr  = '0;

    unique case (state_r)
      S_CLR: begin
        tt_we    = 1'b1;
        tt_waddr = clr_r;
        fl_we    = 1'b1;
        fl_waddr = clr_r[TT_AW-1:BYTE_W];
        ol_we    = 1'b1;
        ol_waddr = clr_r[TT_AW-1:BYTE_W];
        ol_wdata = {SIG_NIL, SIG_NIL};
        clr_nxt  = clr_r + 1'b1;
        if (clr_r == TT_AW'(TT_DEPTH - 1)) begin
          state_nxt = S_IDLE;
        end
      end

      S_IDLE: begin
        if (start) begin
          req_nxt = in_req;
          unique case (in_req.req_type)
            REQ_INSERT: state_nxt = S_INS;
            REQ_BUILD:  state_nxt = S_BLD;
            REQ_SCAN:   state_nxt = S_SC;
            default:    state_nxt = S_BAD;
          endcase
        end
      end

      S_INS: begin
        cur_nxt   = cur0;
        err_nxt   = err0;
        state_nxt = S_INS_END;
        if (err0 == ST_OK) begin
          if (built_r) begin
            err_nxt = ST_INVALID;
          end else begin
            tt_raddr  = {cur0, req_r.data_byte};
            state_nxt = S_INS_RD;
          end
        end
      end

      S_INS_RD: begin
        state_nxt = S_INS_END;
        if (tt_rdata == '0) begin
          if (nodes_r >= (NODE_W + 1)'(NODES)) begin
            err_nxt = ST_FULL;
          end else begin
            tt_we     = 1'b1;
            tt_waddr  = {cur_r, req_r.data_byte};
            tt_wdata  = nodes_r[NODE_W-1:0];
            nodes_nxt = nodes_r + 1'b1;
            cur_nxt   = nodes_r[NODE_W-1:0];
          end
        end else begin
          cur_nxt = tt_rdata;
        end
      end

      S_INS_END: begin
        state_nxt = S_IDLE;
        if (req_r.last) begin
          if (err_r != ST_OK || sigs_r >= (SIG_AW + 1)'(MAX_SIGS)) begin
            out_valid_nxt       = 1'b1;
            out_nxt.result_kind = KIND_STATUS;
            out_nxt.status      = (err_r != ST_OK) ? err_r : ST_FULL;
            out_nxt.last_result = 1'b1;
            cur_nxt             = '0;
            err_nxt             = ST_OK;
          end else begin
            sidx_nxt  = sigs_r[SIG_AW-1:0];
            sigs_nxt  = sigs_r + 1'b1;
            ss_we     = 1'b1;
            ss_waddr  = sigs_r[SIG_AW-1:0];
            ss_wdata  = req_r.pattern_sig;
            sn_we     = 1'b1;
            sn_waddr  = sigs_r[SIG_AW-1:0];
            sn_wdata  = SIG_NIL;
            ol_raddr  = cur_r;
            state_nxt = S_INS_LINK;
          end
        end
      end

      S_INS_LINK: begin
        ol_we    = 1'b1;
        ol_waddr = cur_r;
        if (ol_head >= SIG_NIL) begin
          ol_wdata = {{1'b0, sidx_r}, {1'b0, sidx_r}};
        end else begin
          ol_wdata = {ol_head, {1'b0, sidx_r}};
          sn_we    = 1'b1;
          sn_waddr = ol_tail[SIG_AW-1:0];
          sn_wdata = {1'b0, sidx_r};
        end
        out_valid_nxt       = 1'b1;
        out_nxt.result_kind = KIND_STATUS;
        out_nxt.status      = ST_OK;
        out_nxt.last_result = 1'b1;
        cur_nxt             = '0;
        err_nxt             = ST_OK;
        state_nxt           = S_IDLE;
      end

      S_BLD: begin
        if (built_r) begin
          out_valid_nxt       = 1'b1;
          out_nxt.result_kind = KIND_STATUS;
          out_nxt.status      = ST_OK;
          out_nxt.last_result = 1'b1;
          cur_nxt             = '0;
          hits_nxt            = '0;
          err_nxt             = ST_OK;
          state_nxt           = S_IDLE;
        end else begin
          fl_we     = 1'b1;
          fl_waddr  = '0;
          fl_wdata  = '0;
          c_nxt     = '0;
          qh_nxt    = '0;
          qt_nxt    = '0;
          state_nxt = S_BR_RD;
        end
      end

      S_BR_RD: begin
        tt_raddr  = {{NODE_W{1'b0}}, c_r};
        state_nxt = S_BR_CH;
      end

      S_BR_CH: begin
        if (tt_rdata != '0 && qt_r < (NODE_W + 1)'(NODES)) begin
          fl_we    = 1'b1;
          fl_waddr = tt_rdata;
          fl_wdata = '0;
          q_we     = 1'b1;
          q_waddr  = qt_r[NODE_W-1:0];
          q_wdata  = tt_rdata;
          qt_nxt   = qt_r + 1'b1;
        end
        c_nxt     = c_r + 1'b1;
        state_nxt = (c_r == '1) ? S_BQ : S_BR_RD;
      end

      S_BQ: begin
        if (qh_r < qt_r) begin
          q_raddr   = qh_r[NODE_W-1:0];
          qh_nxt    = qh_r + 1'b1;
          state_nxt = S_BU;
        end else begin
          built_nxt           = 1'b1;
          out_valid_nxt       = 1'b1;
          out_nxt.result_kind = KIND_STATUS;
          out_nxt.status      = ST_OK;
          out_nxt.last_result = 1'b1;
          cur_nxt             = '0;
          hits_nxt            = '0;
          err_nxt             = ST_OK;
          state_nxt           = S_IDLE;
        end
      end

      S_BU: begin
        u_nxt     = q_rdata;
        fl_raddr  = q_rdata;
        state_nxt = S_BF;
      end

      S_BF: begin
        f_nxt     = fl_rdata;
        c_nxt     = '0;
        state_nxt = S_B1;
      end

      S_B1: begin
        tt_raddr  = {u_r, c_r};
        state_nxt = S_B2;
      end

      S_B2: begin
        ch_nxt    = tt_rdata;
        tt_raddr  = {f_r, c_r};
        state_nxt = S_B3;
      end

      S_B3: begin
        // A real child takes the failure node's transition as its failure link and
        // is queued; a missing one takes the transition of the failure node.
        if (ch_r != '0) begin
          fl_we    = 1'b1;
          fl_waddr = ch_r;
          fl_wdata = tt_rdata;
          if (qt_r < (NODE_W + 1)'(NODES)) begin
            q_we    = 1'b1;
            q_waddr = qt_r[NODE_W-1:0];
            q_wdata = ch_r;
            qt_nxt  = qt_r + 1'b1;
          end
        end else begin
          tt_we    = 1'b1;
          tt_waddr = {u_r, c_r};
          tt_wdata = tt_rdata;
        end
        c_nxt     = c_r + 1'b1;
        state_nxt = (c_r == '1) ? S_BQ : S_B1;
      end

      S_SC: begin
        cur_nxt  = cur0;
        hits_nxt = hits0;
        if (!built_r) begin
          state_nxt = S_IDLE;
          if (req_r.last) begin
            out_valid_nxt       = 1'b1;
            out_nxt.result_kind = KIND_STATUS;
            out_nxt.status      = ST_INVALID;
            out_nxt.last_result = 1'b1;
            cur_nxt             = '0;
            hits_nxt            = '0;
          end
        end else begin
          tt_raddr  = {cur0, req_r.data_byte};
          state_nxt = S_SN;
        end
      end

      S_SN: begin
        cur_nxt   = tt_rdata;
        nd_nxt    = tt_rdata;
        ol_raddr  = tt_rdata;
        pass_nxt  = 1'b0;
        n_nxt     = '0;
        hc_nxt    = hits_r;
        trunc_nxt = 1'b0;
        state_nxt = S_WH;
      end

      S_WH: begin
        s_nxt     = ol_head;
        state_nxt = S_WS;
      end

      S_WS: begin
        if (s_r < SIG_NIL && hc_r < maxm_r && n_r < HIT_W'(MAX_HITS_PER_BYTE)) begin
          n_nxt     = n_r + 1'b1;
          hc_nxt    = hc_r + 1'b1;
          ss_raddr  = s_r[SIG_AW-1:0];
          sn_raddr  = s_r[SIG_AW-1:0];
          state_nxt = S_WN;
        end else if (s_r >= SIG_NIL && nd_r != '0) begin
          fl_raddr  = nd_r;
          state_nxt = S_WF;
        end else begin
          // The walk ends here: end of the chain, buffer limit or byte limit.
          if (s_r < SIG_NIL && hc_r < maxm_r) begin
            trunc_nxt = 1'b1;
          end
          if (!pass_r) begin
            // The counting pass is done; replay the walk and emit the hits.
            ntot_nxt  = n_r;
            pass_nxt  = 1'b1;
            n_nxt     = '0;
            hc_nxt    = hits_r;
            nd_nxt    = cur_r;
            ol_raddr  = cur_r;
            state_nxt = S_WH;
          end else begin
            hits_nxt  = hc_r;
            state_nxt = S_IDLE;
            if (req_r.last) begin
              out_valid_nxt       = 1'b1;
              out_nxt.result_kind = KIND_STATUS;
              out_nxt.match_total = hc_r;
              out_nxt.status      = (hc_r != '0) ? ST_OK : ST_NOT_FOUND;
              out_nxt.truncated   = trunc_r;
              out_nxt.last_result = 1'b1;
              cur_nxt             = '0;
              hits_nxt            = '0;
            end
          end
        end
      end

      S_WN: begin
        s_nxt = sn_rdata;
        if (pass_r) begin
          out_valid_nxt         = 1'b1;
          out_nxt.result_kind   = KIND_HIT;
          out_nxt.hit_signature = ss_rdata;
          out_nxt.truncated     = trunc_r;
          out_nxt.last_result   = !req_r.last && (n_r == ntot_r);
        end
        state_nxt = S_WS;
      end

      S_WF: begin
        nd_nxt    = fl_rdata;
        ol_raddr  = fl_rdata;
        state_nxt = S_WH;
      end

      S_BAD: begin
        out_valid_nxt       = 1'b1;
        out_nxt.result_kind = KIND_STATUS;
        out_nxt.status      = ST_INVALID;
        out_nxt.last_result = 1'b1;
        state_nxt           = S_IDLE;
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      clr_r       <= '0;
      cur_r       <= '0;
      nodes_r     <= (NODE_W + 1)'(1);
      sigs_r      <= '0;
      built_r     <= 1'b0;
      hits_r      <= '0;
      err_r       <= ST_OK;
      maxm_r      <= 16'd64;
      qh_r        <= '0;
      qt_r        <= '0;
      pass_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      cur_r       <= cur_nxt;
      nodes_r     <= nodes_nxt;
      sigs_r      <= sigs_nxt;
      built_r     <= built_nxt;
      hits_r      <= hits_nxt;
      err_r       <= err_nxt;
      maxm_r      <= maxm_nxt;
      qh_r        <= qh_nxt;
      qt_r        <= qt_nxt;
      pass_r      <= pass_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_r   <= req_nxt;
    sidx_r  <= sidx_nxt;
    c_r     <= c_nxt;
    u_r     <= u_nxt;
    f_r     <= f_nxt;
    ch_r    <= ch_nxt;
    nd_r    <= nd_nxt;
    s_r     <= s_nxt;
    n_r     <= n_nxt;
    ntot_r  <= ntot_nxt;
    hc_r    <= hc_nxt;
    trunc_r <= trunc_nxt;
    out_r   <= out_nxt;
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_res   = out_r;

`ifndef SYNTHESIS
  a_nodes_bound: assert property (@(posedge clk) disable iff (!rst_n)
    nodes_r <= (NODE_W + 1)'(NODES))
    else $error("node count beyond table size");

  a_sigs_bound: assert property (@(posedge clk) disable iff (!rst_n)
    sigs_r <= (SIG_AW + 1)'(MAX_SIGS))
    else $error("signature count beyond table size");

  a_hit_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_res.result_kind == KIND_HIT |->
      out_res.status == ST_OK && out_res.match_total == '0)
    else $error("hit result carries status fields");

  a_replay_count: assert property (@(posedge clk) disable iff (!rst_n)
    pass_r && (state_r == S_WS || state_r == S_WN) |-> n_r <= ntot_r)
    else $error("emit pass exceeds counted hits");

  a_queue_order: assert property (@(posedge clk) disable iff (!rst_n)
    qh_r <= qt_r)
    else $error("queue head passed its tail");
`endif

endmodule

/* hw/rtl/ac_ram.sv */
// ----------------------------------------------------------------------------
// ac_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module ac_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

/* sim/ac_match_checker.sv */
// ----------------------------------------------------------------------------
// ac_match_checker: result predictor and comparator for the matcher
// Watches the request, result and register ports, keeps its own copy of the
// trie, failure links and signature lists, and compares every result with
// the oldest predicted one.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module ac_match_checker
  import ac_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  input  logic     busy,
  input  in_req_t  in_req,
  input  logic     out_valid,
  input  out_res_t out_res,
  input  logic     cfg_we,
  input  logic [15:0] cfg_wdata,
  output int       errors,
  output int       pending
);

  logic [7:0]  next_node [NODES*ALPHABET];
  logic [7:0]  fail_to [NODES];
  logic [8:0]  sig_head [NODES];
  logic [8:0]  sig_tail [NODES];
  logic [31:0] sig_val [MAX_SIGS];
  logic [8:0]  sig_link [MAX_SIGS];
  int          used_nodes;
  int          sig_count;
  bit          is_built;
  logic [7:0]  cur_node;
  int          buf_hits;
  logic [1:0]  pat_err;
  int          hit_limit;

  out_res_t    expected_results[$];

  assign pending = expected_results.size();

  function automatic out_res_t mk_res(logic kind, logic [31:0] sig, logic [15:0] total,
                                      logic [1:0] st);
    out_res_t r;
    r.result_kind   = kind;
    r.hit_signature = sig;
    r.match_total   = total;
    r.status        = st;
    r.truncated     = 1'b0;
    r.last_result   = 1'b0;
    return r;
  endfunction

  task automatic build_links();
    int bfs [NODES];
    int qh, qt, u, f, ch, via;
    qh = 0;
    qt = 0;
    fail_to[0] = 0;
    for (int c = 0; c < ALPHABET; c++) begin
      ch = next_node[c];
      if (ch != 0 && qt < NODES) begin
        fail_to[ch] = 0;
        bfs[qt++] = ch;
      end
    end
    while (qh < qt) begin
      u = bfs[qh++];
      f = fail_to[u];
      for (int c = 0; c < ALPHABET; c++) begin
        ch  = next_node[u*ALPHABET + c];
        via = next_node[f*ALPHABET + c];
        if (ch != 0) begin
          fail_to[ch] = via[7:0];
          if (qt < NODES) bfs[qt++] = ch;
        end else begin
          next_node[u*ALPHABET + c] = via[7:0];
        end
      end
    end
    is_built = 1'b1;
  endtask

  task automatic predict_request(in_req_t rq);
    out_res_t r;
    out_res_t hits[$];
    int nx, idx, s, walked, nd;
    bit trunc, stop;
    out_res_t one;
    case (rq.req_type)
      REQ_INSERT: begin
        if (rq.first) begin
          cur_node = 0;
          pat_err  = ST_OK;
        end
        if (pat_err == ST_OK) begin
          if (is_built) begin
            pat_err = ST_INVALID;
          end else begin
            idx = int'({cur_node, rq.data_byte});
            nx  = int'(next_node[idx]);
            if (nx == 0) begin
              if (used_nodes >= NODES) begin
                pat_err = ST_FULL;
              end else begin
                nx = used_nodes++;
                next_node[idx] = nx[7:0];
              end
            end
            if (pat_err == ST_OK) cur_node = nx[7:0];
          end
        end
        if (rq.last) begin
          if (pat_err == ST_OK) begin
            if (sig_count >= MAX_SIGS) begin
              pat_err = ST_FULL;
            end else begin
              s = sig_count++;
              sig_val[s]  = rq.pattern_sig;
              sig_link[s] = SIG_NIL;
              if (sig_head[cur_node] >= SIG_NIL) sig_head[cur_node] = s[8:0];
              else sig_link[sig_tail[cur_node]] = s[8:0];
              sig_tail[cur_node] = s[8:0];
            end
          end
          r = mk_res(KIND_STATUS, '0, '0, pat_err);
          r.last_result = 1'b1;
          expected_results.push_back(r);
          cur_node = 0;
          pat_err  = ST_OK;
        end
      end
      REQ_BUILD: begin
        if (!is_built) build_links();
        cur_node = 0;
        buf_hits = 0;
        pat_err  = ST_OK;
        r = mk_res(KIND_STATUS, '0, '0, ST_OK);
        r.last_result = 1'b1;
        expected_results.push_back(r);
      end
      REQ_SCAN: begin
        trunc = 0;
        stop  = 0;
        if (rq.first) begin
          cur_node = 0;
          buf_hits = 0;
        end
        if (!is_built) begin
          if (rq.last) begin
            r = mk_res(KIND_STATUS, '0, '0, ST_INVALID);
            r.last_result = 1'b1;
            expected_results.push_back(r);
            cur_node = 0;
            buf_hits = 0;
          end
        end else begin
          cur_node = next_node[{cur_node, rq.data_byte}];
          nd = int'(cur_node);
          // Own signatures first, then those of each node on the failure chain.
          for (int steps = 0; steps < NODES && !stop; steps++) begin
            s = int'(sig_head[nd]);
            walked = 0;
            while (s < SIG_NIL && walked < MAX_SIGS) begin
              if (buf_hits >= hit_limit) begin
                stop = 1;
                break;
              end
              if (hits.size() >= MAX_HITS_PER_BYTE) begin
                trunc = 1;
                stop  = 1;
                break;
              end
              hits.push_back(mk_res(KIND_HIT, sig_val[s], '0, ST_OK));
              buf_hits++;
              s = int'(sig_link[s]);
              walked++;
            end
            if (nd == 0) break;
            nd = int'(fail_to[nd]);
          end
          if (rq.last) begin
            hits.push_back(mk_res(KIND_STATUS, '0, buf_hits[15:0],
                                  buf_hits > 0 ? ST_OK : ST_NOT_FOUND));
            cur_node = 0;
            buf_hits = 0;
          end
          for (int k = 0; k < hits.size(); k++) begin
            one = hits[k];
            one.truncated   = trunc;
            one.last_result = (k == hits.size() - 1);
            expected_results.push_back(one);
          end
        end
      end
      default: begin
        r = mk_res(KIND_STATUS, '0, '0, ST_INVALID);
        r.last_result = 1'b1;
        expected_results.push_back(r);
      end
    endcase
  endtask

  task automatic check_result(out_res_t got);
    out_res_t want;
    if (expected_results.size() == 0) begin
      $display("%0t: unexpected result %h", $time, got);
      errors++;
      return;
    end
    want = expected_results.pop_front();
    if (got !== want) begin
      errors++;
      if (got.result_kind !== want.result_kind)
        $display("%0t: result_kind expected %h got %h", $time, want.result_kind,
                 got.result_kind);
      if (got.hit_signature !== want.hit_signature)
        $display("%0t: hit_signature expected %h got %h", $time, want.hit_signature,
                 got.hit_signature);
      if (got.match_total !== want.match_total)
        $display("%0t: match_total expected %h got %h", $time, want.match_total,
                 got.match_total);
      if (got.status !== want.status)
        $display("%0t: status expected %h got %h", $time, want.status, got.status);
      if (got.truncated !== want.truncated)
        $display("%0t: truncated expected %h got %h", $time, want.truncated,
                 got.truncated);
      if (got.last_result !== want.last_result)
        $display("%0t: last_result expected %h got %h", $time, want.last_result,
                 got.last_result);
    end
  endtask

  initial begin
    errors = 0;
    for (int i = 0; i < NODES*ALPHABET; i++) next_node[i] = '0;
    for (int i = 0; i < NODES; i++) begin
      fail_to[i]  = '0;
      sig_head[i] = SIG_NIL;
      sig_tail[i] = SIG_NIL;
    end
    used_nodes = 1;
    sig_count  = 0;
    is_built   = 0;
    cur_node   = 0;
    buf_hits   = 0;
    pat_err    = ST_OK;
    hit_limit  = 64;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_we) hit_limit = int'(cfg_wdata);
      if (start && !busy) predict_request(in_req);
      if (out_valid) check_result(out_res);
    end
  end

endmodule

/* sim/tb_aho_corasick_matcher.sv */
// ----------------------------------------------------------------------------
// tb_aho_corasick_matcher: testbench of the Aho-Corasick matcher
// Inserts patterns until the node and signature tables fill, builds the
// automaton and scans random buffers under several hit limits, with bursty
// request timing; the checker predicts and compares every result.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_aho_corasick_matcher;
  import ac_pkg::*;

  localparam logic [1:0] REQ_UNKNOWN = 2'd3;

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  in_req_t     in_req;
  logic        out_valid;
  out_res_t    out_res;
  logic        cfg_we;
  logic [15:0] cfg_wdata;
  int          errors;
  int          pending;
  int          burst_left;

  // Bytes that patterns and most scanned data are drawn from.
  logic [7:0]  pat_bytes [5] = '{8'h61, 8'h62, 8'h63, 8'h00, 8'hFF};

  aho_corasick_matcher uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_req    (in_req),
    .out_valid (out_valid),
    .out_res   (out_res),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  ac_match_checker u_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_req    (in_req),
    .out_valid (out_valid),
    .out_res   (out_res),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .errors    (errors),
    .pending   (pending)
  );

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  initial begin
    #20000000;
    $display("simulation failed");
    $finish;
  end

  // Mostly pattern bytes, sometimes the byte that carries many signatures.
  function automatic logic [7:0] pick_byte();
    return ($urandom_range(0, 9) == 0) ? 8'($urandom) :
           ($urandom_range(0, 9) == 0) ? 8'h01 : pat_bytes[$urandom_range(0, 4)];
  endfunction

  // Issues one request; start stays high while the burst continues.
  task automatic send_req(logic [1:0] kind, logic [7:0] data, logic first, logic last,
                          logic [31:0] sig);
    in_req_t rq;
    rq.req_type    = kind;
    rq.data_byte   = data;
    rq.first       = first;
    rq.last        = last;
    rq.pattern_sig = sig;
    in_req <= rq;
    start  <= 1'b1;
    do @(posedge clk); while (busy);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      start <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = ($urandom_range(0, 7) == 0) ? 40 : $urandom_range(0, 8);
    end
  endtask

  task automatic wait_idle();
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0 || busy) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic set_limit(logic [15:0] value);
    wait_idle();
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  task automatic insert_pattern(int len, logic first_flag, logic [31:0] sig);
    for (int i = 0; i < len; i++)
      send_req(REQ_INSERT, pat_bytes[$urandom_range(0, 4)], first_flag && i == 0,
               i == len - 1, sig);
  endtask

  task automatic scan_buffers(int count);
    int len;
    for (int b = 0; b < count; b++) begin
      len = $urandom_range(1, 6);
      if ($urandom_range(0, 19) == 0) send_req(REQ_UNKNOWN, 8'($urandom), 1'b0, 1'b0, '0);
      for (int i = 0; i < len; i++)
        send_req(REQ_SCAN, pick_byte(), i == 0 && $urandom_range(0, 9) != 0,
                 i == len - 1, $urandom);
    end
  endtask

  initial begin
    rst_n      = 1'b0;
    start      = 1'b0;
    in_req     = '0;
    cfg_we     = 1'b0;
    cfg_wdata  = '0;
    burst_left = 0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);

    set_limit(16'hFFFF);
    // Scanning before the automaton exists, and an unknown request.
    send_req(REQ_SCAN, 8'h61, 1'b1, 1'b0, '0);
    send_req(REQ_SCAN, 8'hFF, 1'b0, 1'b1, 32'hFFFF_FFFF);
    send_req(REQ_UNKNOWN, 8'h00, 1'b1, 1'b1, '0);
    insert_pattern(1, 1'b1, 32'h0000_0000);
    insert_pattern(2, 1'b1, 32'hFFFF_FFFF);
    // A pattern without its first flag continues from the root after a last byte.
    insert_pattern(3, 1'b0, 32'h1234_5678);
    for (int p = 0; p < 35; p++)
      insert_pattern($urandom_range(1, 3), 1'b1, $urandom);

    // Many signatures on one node push a single scanned byte past the per-byte limit.
    for (int p = 0; p < 70; p++)
      send_req(REQ_INSERT, 8'h01, 1'b1, 1'b1, $urandom);

    // Single-byte patterns of fresh bytes fill the signature table, then the node table.
    for (int v = 2; v < 255; v++)
      if (v < 'h61 || v > 'h63)
        send_req(REQ_INSERT, 8'(v), 1'b1, 1'b1, $urandom);

    send_req(REQ_BUILD, 8'($urandom), 1'b1, 1'b1, $urandom);
    send_req(REQ_BUILD, 8'($urandom), 1'b0, 1'b0, $urandom);
    insert_pattern(2, 1'b1, $urandom);

    scan_buffers(6);
    set_limit(16'd64);
    scan_buffers(6);
    set_limit(16'd1);
    scan_buffers(4);
    set_limit(16'd0);
    scan_buffers(3);
    set_limit(16'($urandom_range(2, 300)));
    scan_buffers(5);

    wait_idle();
    repeat (200) @(posedge clk);
    if (errors == 0 && pending == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
